// ----- src/bpcc_pkg.sv -----
// Shared types, constants and helper functions for the bitmap pixel color converter.
`default_nettype none
package bpcc_pkg;

  localparam int PAL_DEPTH = 256;
  localparam int PAL_AW = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;
  localparam int CU_W = 9;
  localparam logic [CU_W-1:0] PAL_LIM = CU_W'(PAL_DEPTH);

  typedef logic [1:0] req_t;
  localparam req_t REQ_PIX2COL = 2'd0;
  localparam req_t REQ_COL2PIX = 2'd1;
  localparam req_t REQ_PAL_WR  = 2'd2;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_BPP       = 3'd0;
  localparam reg_idx_t REG_COMP      = 3'd1;
  localparam reg_idx_t REG_RED_MASK  = 3'd2;
  localparam reg_idx_t REG_GRN_MASK  = 3'd3;
  localparam reg_idx_t REG_BLU_MASK  = 3'd4;
  localparam reg_idx_t REG_COLORS    = 3'd5;

  localparam logic [5:0] BPP_RESET = 6'd24;

  localparam logic [31:0] M555_R = 32'h0000_7C00;
  localparam logic [31:0] M555_G = 32'h0000_03E0;
  localparam logic [31:0] M555_B = 32'h0000_001F;
  localparam logic [31:0] M888_R = 32'h00FF_0000;
  localparam logic [31:0] M888_G = 32'h0000_FF00;
  localparam logic [31:0] M888_B = 32'h0000_00FF;
  localparam logic [31:0] M24    = 32'h00FF_FFFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] pixel_word;
    logic [2:0]  column_low;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [7:0]  alpha_in;
    logic [7:0]  palette_slot;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [7:0]  alpha_out;
    logic [31:0] pixel_out;
  } out_item_t;

  typedef struct packed {
    logic [5:0]  bits_per_pixel;
    logic        compression_mode;
    logic [31:0] red_mask;
    logic [31:0] green_mask;
    logic [31:0] blue_mask;
    logic [8:0]  colors_used;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_FAIL,
    OP_PAL,
    OP_SPLIT24,
    OP_SPLIT32,
    OP_MASK_DEC,
    OP_PACK24,
    OP_PACK32,
    OP_MASK_ENC,
    OP_PAL_WR
  } op_t;

  typedef struct packed {
    logic        nz;
    logic [5:0]  end_pos;
    logic [31:0] masked;
    logic [31:0] low_zeros;
  } chan_t;

  typedef struct packed {
    op_t         op;
    logic        is16;
    logic [31:0] pix;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;
    chan_t       ch_r;
    chan_t       ch_g;
    chan_t       ch_b;
  } s2_t;

  typedef struct packed {
    logic              rd_en;
    logic [PAL_AW-1:0] rd_idx;
    logic              wr_en;
    logic [PAL_AW-1:0] wr_idx;
    logic [31:0]       wr_data;
  } pal_req_t;

  function automatic logic [5:0] ctz33(input logic [32:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 32; i >= 0; i--) begin
      if (v[i]) begin
        n = 6'(i);
      end
    end
    return n;
  endfunction

  function automatic chan_t prep_chan(input logic [31:0] m, input logic [31:0] p);
    chan_t c;
    logic [31:0] dec;
    dec = m - 32'd1;
    c.nz = (m != '0);
    c.end_pos = ctz33({1'b1, ~(m | dec)});
    c.masked = m & p;
    c.low_zeros = ~m & dec;
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- src/bpcc_palette.sv -----
// Palette memory with per-entry valid bits so that unwritten entries read as zero.
`default_nettype none
module bpcc_palette (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bpcc_pkg::pal_req_t req,
  output logic [31:0]             rd_data
);
  import bpcc_pkg::*;

  logic [31:0]          mem [PAL_DEPTH];
  logic [PAL_DEPTH-1:0] vld_r;
  logic [31:0]          rd_data_r;
  logic                 rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_idx] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_idx] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.rd_idx];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : 32'd0;

endmodule
`default_nettype wire

// ----- src/bpcc_front.sv -----
// First stage: pixel extraction, request classification, mask analysis and palette access.
`default_nettype none
module bpcc_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bpcc_pkg::cfg_t     cfg,
  input  wire logic               s1_valid,
  input  wire bpcc_pkg::in_item_t s1_item,
  input  wire logic               en2,
  output bpcc_pkg::pal_req_t      pal_req,
  output logic                    s2_valid,
  output bpcc_pkg::s2_t           s2
);
  import bpcc_pkg::*;

  logic [5:0]      d;
  logic            d_ok;
  logic            comp;
  logic [31:0]     word;
  logic [31:0]     pix;
  logic [CU_W-1:0] lim_pow;
  logic [CU_W-1:0] lim_raw;
  logic [CU_W-1:0] lim;
  logic            in_range;
  logic            slot_ok;
  logic [31:0]     mr;
  logic [31:0]     mg;
  logic [31:0]     mb;
  op_t             op;
  s2_t             s2_nxt;
  s2_t             s2_r;
  logic            s2_valid_r;

  assign d    = cfg.bits_per_pixel;
  assign comp = cfg.compression_mode;
  assign word = s1_item.pixel_word;
  assign d_ok = (d == 6'd1) || (d == 6'd4) || (d == 6'd8) ||
                (d == 6'd16) || (d == 6'd24) || (d == 6'd32);

  always_comb begin
    case (d)
      6'd1:    pix = {31'd0, word[3'd7 - s1_item.column_low]};
      6'd4:    pix = {28'd0, s1_item.column_low[0] ? word[3:0] : word[7:4]};
      6'd8:    pix = {24'd0, word[7:0]};
      6'd16:   pix = {16'd0, word[15:0]};
      6'd24:   pix = word & M24;
      default: pix = word;
    endcase
  end

  always_comb begin
    case (d)
      6'd1:    lim_pow = CU_W'(2);
      6'd4:    lim_pow = CU_W'(16);
      default: lim_pow = CU_W'(256);
    endcase
    lim_raw  = (cfg.colors_used != '0) ? cfg.colors_used : lim_pow;
    lim      = (lim_raw > PAL_LIM) ? PAL_LIM : lim_raw;
    in_range = (pix[31:CU_W] == '0) && (pix[CU_W-1:0] < lim);
    slot_ok  = ({1'b0, s1_item.palette_slot} < PAL_LIM);
  end

  always_comb begin
    if (comp) begin
      mr = cfg.red_mask;
      mg = cfg.green_mask;
      mb = cfg.blue_mask;
    end else if (d == 6'd16) begin
      mr = M555_R;
      mg = M555_G;
      mb = M555_B;
    end else begin
      mr = M888_R;
      mg = M888_G;
      mb = M888_B;
    end
  end

  always_comb begin
    op = OP_FAIL;
    case (s1_item.req_type)
      REQ_PIX2COL: begin
        if (d_ok) begin
          if (d <= 6'd8) begin
            op = in_range ? OP_PAL : OP_FAIL;
          end else if (d == 6'd24) begin
            op = OP_SPLIT24;
          end else if (d == 6'd32 && !comp) begin
            op = OP_SPLIT32;
          end else begin
            op = OP_MASK_DEC;
          end
        end
      end
      REQ_COL2PIX: begin
        if (d_ok && d > 6'd8) begin
          if (d == 6'd24) begin
            op = OP_PACK24;
          end else if (d == 6'd32 && !comp) begin
            op = OP_PACK32;
          end else begin
            op = OP_MASK_ENC;
          end
        end
      end
      REQ_PAL_WR: begin
        op = slot_ok ? OP_PAL_WR : OP_FAIL;
      end
      default: op = OP_FAIL;
    endcase
  end

  always_comb begin
    s2_nxt.op   = op;
    s2_nxt.is16 = (d == 6'd16);
    s2_nxt.pix  = pix;
    s2_nxt.r    = s1_item.red_in;
    s2_nxt.g    = s1_item.green_in;
    s2_nxt.b    = s1_item.blue_in;
    s2_nxt.a    = s1_item.alpha_in;
    s2_nxt.ch_r = prep_chan(mr, pix);
    s2_nxt.ch_g = prep_chan(mg, pix);
    s2_nxt.ch_b = prep_chan(mb, pix);
  end

  always_comb begin
    pal_req.rd_en   = en2 && s1_valid;
    pal_req.rd_idx  = pix[PAL_AW-1:0];
    pal_req.wr_en   = en2 && s1_valid && (op == OP_PAL_WR);
    pal_req.wr_idx  = s1_item.palette_slot[PAL_AW-1:0];
    pal_req.wr_data = {s1_item.alpha_in, s1_item.red_in, s1_item.green_in, s1_item.blue_in};
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_r <= s2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en2) begin
      s2_valid_r <= s1_valid;
    end
  end

  assign s2       = s2_r;
  assign s2_valid = s2_valid_r;

endmodule
`default_nettype wire

// ----- src/bpcc_back.sv -----
// Second stage: channel decode and pixel packing into the result register.
`default_nettype none
module bpcc_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           s2_valid,
  input  wire bpcc_pkg::s2_t  s2,
  input  wire logic [31:0]    pal_data,
  input  wire logic           en3,
  output logic                out_valid,
  output bpcc_pkg::out_item_t out_item
);
  import bpcc_pkg::*;

  out_item_t   res_nxt;
  out_item_t   res_r;
  logic        out_valid_r;
  logic [7:0]  dec_r;
  logic [7:0]  dec_g;
  logic [7:0]  dec_b;
  logic [31:0] enc_r;
  logic [31:0] enc_g;
  logic [31:0] enc_b;
  logic [31:0] enc_all;

  function automatic logic [7:0] dec_chan(input chan_t c);
    logic [39:0] t;
    t = {c.masked, 8'h00} >> c.end_pos;
    return c.nz ? t[7:0] : 8'h00;
  endfunction

  function automatic logic [31:0] enc_chan(input chan_t c, input logic [7:0] v);
    logic [39:0] t;
    t = {32'd0, v} << c.end_pos;
    return c.nz ? (t[39:8] & ~c.low_zeros) : 32'd0;
  endfunction

  always_comb begin
    dec_r   = dec_chan(s2.ch_r);
    dec_g   = dec_chan(s2.ch_g);
    dec_b   = dec_chan(s2.ch_b);
    enc_r   = enc_chan(s2.ch_r, s2.r);
    enc_g   = enc_chan(s2.ch_g, s2.g);
    enc_b   = enc_chan(s2.ch_b, s2.b);
    enc_all = enc_r | enc_g | enc_b;
  end

  always_comb begin
    res_nxt = '0;
    case (s2.op)
      OP_PAL: begin
        res_nxt.ok        = 1'b1;
        res_nxt.blue_out  = pal_data[7:0];
        res_nxt.green_out = pal_data[15:8];
        res_nxt.red_out   = pal_data[23:16];
        res_nxt.alpha_out = pal_data[31:24];
      end
      OP_SPLIT24: begin
        res_nxt.ok        = 1'b1;
        res_nxt.blue_out  = s2.pix[7:0];
        res_nxt.green_out = s2.pix[15:8];
        res_nxt.red_out   = s2.pix[23:16];
      end
      OP_SPLIT32: begin
        res_nxt.ok        = 1'b1;
        res_nxt.blue_out  = s2.pix[7:0];
        res_nxt.green_out = s2.pix[15:8];
        res_nxt.red_out   = s2.pix[23:16];
        res_nxt.alpha_out = s2.pix[31:24];
      end
      OP_MASK_DEC: begin
        res_nxt.ok        = 1'b1;
        res_nxt.red_out   = dec_r;
        res_nxt.green_out = dec_g;
        res_nxt.blue_out  = dec_b;
      end
      OP_PACK24: begin
        res_nxt.ok        = 1'b1;
        res_nxt.pixel_out = {8'h00, s2.r, s2.g, s2.b};
      end
      OP_PACK32: begin
        res_nxt.ok        = 1'b1;
        res_nxt.pixel_out = {s2.a, s2.r, s2.g, s2.b};
      end
      OP_MASK_ENC: begin
        res_nxt.ok        = 1'b1;
        res_nxt.pixel_out = s2.is16 ? {16'h0000, enc_all[15:0]} : enc_all;
      end
      OP_PAL_WR: begin
        res_nxt.ok = 1'b1;
      end
      default: res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en3) begin
      out_valid_r <= s2_valid;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = res_r;

endmodule
`default_nettype wire

// ----- src/bitmap_pixel_color_converter_core.sv -----
// Top level of the bitmap pixel color converter: registers, input stage and pipeline.
// Each item passes through the input, stage and result registers in turn.
// Throughput: one item per cycle; each stage advances when the stage after it is free.
// The palette memory has one read and one write port, both used in the first stage.
// Reset is synchronous and active low; it clears valid flags, configuration registers and palette valid bits.
`default_nettype none
module bitmap_pixel_color_converter_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire bpcc_pkg::in_item_t in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output bpcc_pkg::out_item_t     out_item,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_wdata
);
  import bpcc_pkg::*;

  cfg_t     cfg_r;
  in_item_t s1_item_r;
  logic     s1_valid_r;
  logic     en2;
  logic     en3;
  logic     s2_valid;
  s2_t      s2;
  pal_req_t pal_req;
  logic [31:0] pal_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bits_per_pixel   <= BPP_RESET;
      cfg_r.compression_mode <= 1'b0;
      cfg_r.red_mask         <= '0;
      cfg_r.green_mask       <= '0;
      cfg_r.blue_mask        <= '0;
      cfg_r.colors_used      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BPP:      cfg_r.bits_per_pixel   <= cfg_wdata[5:0];
        REG_COMP:     cfg_r.compression_mode <= cfg_wdata[0];
        REG_RED_MASK: cfg_r.red_mask         <= cfg_wdata;
        REG_GRN_MASK: cfg_r.green_mask       <= cfg_wdata;
        REG_BLU_MASK: cfg_r.blue_mask        <= cfg_wdata;
        REG_COLORS:   cfg_r.colors_used      <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  assign en3      = !out_valid || out_ready;
  assign en2      = !s2_valid || en3;
  assign in_ready = !s1_valid_r || en2;

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  bpcc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .s1_valid (s1_valid_r),
    .s1_item  (s1_item_r),
    .en2      (en2),
    .pal_req  (pal_req),
    .s2_valid (s2_valid),
    .s2       (s2)
  );

  bpcc_palette u_palette (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (pal_req),
    .rd_data (pal_data)
  );

  bpcc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .s2_valid  (s2_valid),
    .s2        (s2),
    .pal_data  (pal_data),
    .en3       (en3),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// ----- bench/bitmap_pixel_color_converter_core_tb.sv -----
// Self-checking testbench for the bitmap pixel color converter with shadow palette and registers.
`default_nettype none
module bitmap_pixel_color_converter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bpcc_pkg::*;

  localparam req_t REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_COUNT = 13;
  localparam int ITEMS_PER_PHASE = 50;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  logic [5:0]  shadow_bpp = BPP_RESET;
  logic        shadow_comp = 1'b0;
  logic [31:0] shadow_rmask = '0;
  logic [31:0] shadow_gmask = '0;
  logic [31:0] shadow_bmask = '0;
  logic [8:0]  shadow_colors = '0;
  logic [31:0] pal_shadow [PAL_DEPTH] = '{default: '0};

  in_item_t  pixel_reqs [$];
  out_item_t pending_results [$];

  int items_queued = 0;
  int results_seen = 0;
  int err_cnt = 0;
  int phase_cnt = 0;
  int cycle_cnt = 0;
  int burst_left = 1;
  int gap_left = 0;
  int n_pal_wr = 0;
  int n_reads = 0;
  int n_packs = 0;
  int n_other = 0;
  logic [9:0] stall_phase = '0;

  bitmap_pixel_color_converter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic bit depth_ok(input int unsigned d);
    return d == 1 || d == 4 || d == 8 || d == 16 || d == 24 || d == 32;
  endfunction

  function automatic int unsigned low_zero_count(input logic [31:0] m);
    int unsigned n;
    n = 0;
    if (m == '0) return 0;
    while (!m[0]) begin
      m = m >> 1;
      n++;
    end
    return n;
  endfunction

  function automatic int unsigned ones_run(input logic [31:0] m);
    int unsigned n;
    n = 0;
    m = m >> low_zero_count(m);
    while (m[0]) begin
      m = m >> 1;
      n++;
    end
    return n;
  endfunction

  function automatic logic [7:0] unpack_chan(input logic [31:0] mask, input logic [31:0] pix);
    logic [31:0] v;
    int unsigned run;
    if (mask == '0) return '0;
    run = ones_run(mask);
    v = (mask & pix) >> low_zero_count(mask);
    if (run <= 8) v = v << (8 - run);
    else v = v >> (run - 8);
    return v[7:0];
  endfunction

  function automatic logic [31:0] pack_chan(input logic [31:0] mask, input logic [7:0] c);
    logic [63:0] v;
    int unsigned run;
    if (mask == '0) return '0;
    run = ones_run(mask);
    if (run <= 8) v = 64'(c >> (8 - run));
    else v = 64'(c) << (run - 8);
    v = v << low_zero_count(mask);
    return v[31:0];
  endfunction

  function automatic void chan_masks(input int unsigned d, output logic [31:0] mr,
                                     output logic [31:0] mg, output logic [31:0] mb);
    if (shadow_comp) begin
      mr = shadow_rmask;
      mg = shadow_gmask;
      mb = shadow_bmask;
    end else if (d == 16) begin
      mr = M555_R;
      mg = M555_G;
      mb = M555_B;
    end else begin
      mr = M888_R;
      mg = M888_G;
      mb = M888_B;
    end
  endfunction

  // Expected result of one item; palette writes update the shadow palette.
  function automatic out_item_t convert_pixel(input in_item_t it);
    out_item_t res;
    logic [31:0] pix, ent, mr, mg, mb;
    int unsigned d, lim;
    res = '0;
    pix = '0;
    d = 32'(shadow_bpp);
    case (it.req_type)
      REQ_PIX2COL: begin
        if (depth_ok(d)) begin
          case (d)
            1: pix = {31'd0, it.pixel_word[3'd7 - it.column_low]};
            4: pix = {28'd0, it.column_low[0] ? it.pixel_word[3:0] : it.pixel_word[7:4]};
            8: pix = {24'd0, it.pixel_word[7:0]};
            16: pix = {16'd0, it.pixel_word[15:0]};
            24: pix = {8'd0, it.pixel_word[23:0]};
            default: pix = it.pixel_word;
          endcase
          if (d <= 8) begin
            lim = (shadow_colors != '0) ? 32'(shadow_colors) : (32'd1 << d);
            if (lim > PAL_DEPTH) lim = PAL_DEPTH;
            if (pix < lim) begin
              ent = pal_shadow[pix[7:0]];
              res.ok = 1'b1;
              res.blue_out = ent[7:0];
              res.green_out = ent[15:8];
              res.red_out = ent[23:16];
              res.alpha_out = ent[31:24];
            end
          end else if (d == 24 || (d == 32 && !shadow_comp)) begin
            res.ok = 1'b1;
            res.blue_out = pix[7:0];
            res.green_out = pix[15:8];
            res.red_out = pix[23:16];
            res.alpha_out = pix[31:24];
          end else begin
            chan_masks(d, mr, mg, mb);
            res.ok = 1'b1;
            res.red_out = unpack_chan(mr, pix);
            res.green_out = unpack_chan(mg, pix);
            res.blue_out = unpack_chan(mb, pix);
          end
        end
      end
      REQ_COL2PIX: begin
        if (depth_ok(d) && d > 8) begin
          res.ok = 1'b1;
          if (d == 24) begin
            res.pixel_out = {8'd0, it.red_in, it.green_in, it.blue_in};
          end else if (d == 32 && !shadow_comp) begin
            res.pixel_out = {it.alpha_in, it.red_in, it.green_in, it.blue_in};
          end else begin
            chan_masks(d, mr, mg, mb);
            res.pixel_out = pack_chan(mr, it.red_in) | pack_chan(mg, it.green_in)
                          | pack_chan(mb, it.blue_in);
            if (d == 16) res.pixel_out[31:16] = '0;
          end
        end
      end
      REQ_PAL_WR: begin
        pal_shadow[it.palette_slot] = {it.alpha_in, it.red_in, it.green_in, it.blue_in};
        res.ok = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      err_cnt++;
    end
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  task automatic program_regs(input logic [5:0] bpp, input logic comp, input logic [31:0] rm,
                              input logic [31:0] gm, input logic [31:0] bm,
                              input logic [8:0] cu);
    write_reg(REG_BPP, 32'(bpp));
    write_reg(REG_COMP, 32'(comp));
    write_reg(REG_RED_MASK, rm);
    write_reg(REG_GRN_MASK, gm);
    write_reg(REG_BLU_MASK, bm);
    write_reg(REG_COLORS, 32'(cu));
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_bpp = bpp;
    shadow_comp = comp;
    shadow_rmask = rm;
    shadow_gmask = gm;
    shadow_bmask = bm;
    shadow_colors = cu;
    phase_cnt++;
  endtask

  task automatic enqueue(input in_item_t it);
    pixel_reqs.push_back(it);
    items_queued++;
  endtask

  task automatic dir_req(input req_t req, input logic [31:0] word, input logic [2:0] col,
                         input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                         input logic [7:0] a, input logic [7:0] slot);
    in_item_t it;
    it.req_type = req;
    it.pixel_word = word;
    it.column_low = col;
    it.red_in = r;
    it.green_in = g;
    it.blue_in = b;
    it.alpha_in = a;
    it.palette_slot = slot;
    enqueue(it);
  endtask

  task automatic queue_random(input int n);
    in_item_t it;
    int sel;
    for (int i = 0; i < n; i++) begin
      it.pixel_word = $urandom;
      it.column_low = 3'($urandom_range(0, 7));
      it.red_in = 8'($urandom_range(0, 255));
      it.green_in = 8'($urandom_range(0, 255));
      it.blue_in = 8'($urandom_range(0, 255));
      it.alpha_in = 8'($urandom_range(0, 255));
      it.palette_slot = $urandom_range(0, 1) ? 8'($urandom_range(0, 15))
                                              : 8'($urandom_range(0, 255));
      sel = $urandom_range(0, 99);
      if (shadow_bpp <= 8 && depth_ok(32'(shadow_bpp))) begin
        if (sel < 30) it.req_type = REQ_PAL_WR;
        else if (sel < 85) it.req_type = REQ_PIX2COL;
        else if (sel < 95) it.req_type = REQ_COL2PIX;
        else it.req_type = REQ_UNUSED;
      end else begin
        if (sel < 10) it.req_type = REQ_PAL_WR;
        else if (sel < 55) it.req_type = REQ_PIX2COL;
        else if (sel < 95) it.req_type = REQ_COL2PIX;
        else it.req_type = REQ_UNUSED;
      end
      // Keep palette indices small often enough to land inside short palettes.
      if (it.req_type == REQ_PIX2COL && shadow_bpp <= 8 && $urandom_range(0, 1))
        it.pixel_word[7:0] = 8'($urandom_range(0, 15));
      enqueue(it);
    end
  endtask

  task automatic drain();
    while (results_seen < items_queued) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  function automatic logic [31:0] make_mask();
    logic [31:0] m;
    int unsigned tz, run;
    case ($urandom_range(0, 7))
      0: m = '0;
      1: m = '1;
      2, 3: m = $urandom;
      default: begin
        tz = $urandom_range(0, 31);
        run = $urandom_range(1, 32 - tz);
        m = 32'((64'd1 << run) - 64'd1) << tz;
      end
    endcase
    return m;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pending_results.push_back(convert_pixel(in_item));
        case (in_item.req_type)
          REQ_PAL_WR: n_pal_wr++;
          REQ_PIX2COL: n_reads++;
          REQ_COL2PIX: n_packs++;
          default: n_other++;
        endcase
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pixel_reqs.size() != 0) begin
          in_item <= pixel_reqs.pop_front();
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compares each result and stalls on a rotating pattern.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result received with no item outstanding");
          err_cnt++;
        end else begin
          out_item_t want;
          want = pending_results.pop_front();
          check_field("ok", 32'(want.ok), 32'(out_item.ok));
          check_field("red_out", 32'(want.red_out), 32'(out_item.red_out));
          check_field("green_out", 32'(want.green_out), 32'(out_item.green_out));
          check_field("blue_out", 32'(want.blue_out), 32'(out_item.blue_out));
          check_field("alpha_out", 32'(want.alpha_out), 32'(out_item.alpha_out));
          check_field("pixel_out", want.pixel_out, out_item.pixel_out);
          results_seen++;
        end
      end
      stall_phase <= stall_phase + 10'd1;
      case (stall_phase[9:8])
        2'd0: out_ready <= 1'b1;
        2'd1: out_ready <= (stall_phase[1:0] != 2'd3);
        2'd2: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= (stall_phase[3:0] < 4'd5);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timed out with %0d of %0d results received.", results_seen, items_queued);
      $display("** bitmap_pixel_color_converter_core: FAILED **");
      $finish;
    end
  end

  initial begin
    int unsigned depth_plan [PHASE_COUNT];
    logic [8:0] cu;
    depth_plan = '{1, 4, 8, 16, 24, 32, 32, 16, 8, 0, 63, 4, 1};
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset configuration: 24-bit plain, palette loads, reads, a pack and the unknown request.
    dir_req(REQ_PAL_WR, '0, 3'd0, 8'h22, 8'h33, 8'h44, 8'h11, 8'd0);
    dir_req(REQ_PAL_WR, '1, 3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd255);
    dir_req(REQ_PAL_WR, '0, 3'd0, 8'h7F, 8'h01, 8'hFE, 8'h80, 8'd1);
    dir_req(REQ_PIX2COL, 32'hFFFF_FFFF, 3'd0, '0, '0, '0, '0, '0);
    dir_req(REQ_PIX2COL, 32'h0000_0000, 3'd7, '1, '1, '1, '1, '1);
    dir_req(REQ_COL2PIX, '0, 3'd0, 8'hFF, 8'h00, 8'hFF, 8'hFF, '0);
    dir_req(REQ_UNUSED, 32'hDEAD_BEEF, 3'd5, 8'h12, 8'h34, 8'h56, 8'h78, 8'd9);
    drain();
    // Depth 24 splits bytes even with bitfields selected.
    program_regs(6'd24, 1'b1, 32'h0000_000F, 32'h0000_00F0, 32'h0000_0F00, 9'd0);
    dir_req(REQ_PIX2COL, 32'h1234_5678, 3'd0, '0, '0, '0, '0, '0);
    dir_req(REQ_COL2PIX, '0, 3'd0, 8'h12, 8'h34, 8'h56, 8'h9A, '0);
    drain();
    program_regs(6'd1, 1'b0, '0, '0, '0, 9'd0);
    dir_req(REQ_PIX2COL, 32'h0000_0080, 3'd0, '0, '0, '0, '0, '0);
    dir_req(REQ_PIX2COL, 32'h0000_0080, 3'd7, '0, '0, '0, '0, '0);
    dir_req(REQ_PIX2COL, 32'hFFFF_FF01, 3'd7, '0, '0, '0, '0, '0);
    dir_req(REQ_COL2PIX, '0, 3'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, '0);
    drain();
    program_regs(6'd4, 1'b0, '0, '0, '0, 9'd2);
    dir_req(REQ_PIX2COL, 32'h0000_00F0, 3'd0, '0, '0, '0, '0, '0);
    dir_req(REQ_PIX2COL, 32'h0000_0001, 3'd1, '0, '0, '0, '0, '0);
    drain();
    program_regs(6'd8, 1'b0, '0, '0, '0, 9'd256);
    dir_req(REQ_PIX2COL, 32'h0000_00FF, 3'd0, '0, '0, '0, '0, '0);
    drain();
    program_regs(6'd16, 1'b0, '1, '1, '1, 9'd0);
    dir_req(REQ_PIX2COL, 32'h0000_FFFF, 3'd0, '0, '0, '0, '0, '0);
    dir_req(REQ_COL2PIX, '0, 3'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, '0);
    drain();
    // Long runs keep their top bits; a zero mask yields zero.
    program_regs(6'd32, 1'b1, 32'hFFF0_0000, 32'h000F_F000, 32'h0000_0000, 9'd0);
    dir_req(REQ_PIX2COL, 32'hFFFF_FFFF, 3'd0, '0, '0, '0, '0, '0);
    dir_req(REQ_COL2PIX, '0, 3'd0, 8'hFF, 8'hA5, 8'hFF, 8'hFF, '0);
    drain();
    program_regs(6'd32, 1'b0, '0, '0, '0, 9'd0);
    dir_req(REQ_PIX2COL, 32'hA1B2_C3D4, 3'd0, '0, '0, '0, '0, '0);
    dir_req(REQ_COL2PIX, '0, 3'd0, 8'h01, 8'h02, 8'h03, 8'hF4, '0);
    drain();
    program_regs(6'd0, 1'b0, '0, '0, '0, 9'd0);
    dir_req(REQ_PIX2COL, 32'h0102_0304, 3'd0, '0, '0, '0, '0, '0);
    dir_req(REQ_COL2PIX, '0, 3'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, '0);
    drain();
    program_regs(6'd63, 1'b1, '1, '1, '1, 9'd256);
    dir_req(REQ_PIX2COL, 32'hFFFF_FFFF, 3'd7, '0, '0, '0, '0, '0);
    drain();

    for (int k = 0; k < PHASE_COUNT; k++) begin
      case (k % 4)
        0: cu = 9'd0;
        1: cu = 9'd256;
        2: cu = 9'd1;
        default: cu = 9'($urandom_range(1, 255));
      endcase
      program_regs(6'(depth_plan[k]), (k % 3) == 0, make_mask(), make_mask(), make_mask(), cu);
      queue_random(ITEMS_PER_PHASE);
      drain();
    end

    repeat (8) @(posedge clk);
    $display("Checked %0d results across %0d register settings.", results_seen, phase_cnt + 1);
    $display("Items: %0d palette writes, %0d pixel reads, %0d packs, %0d unknown requests.",
             n_pal_wr, n_reads, n_packs, n_other);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("** bitmap_pixel_color_converter_core: PASSED **");
    end else begin
      $display("** bitmap_pixel_color_converter_core: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
src/bpcc_pkg.sv
src/bpcc_palette.sv
src/bpcc_front.sv
src/bpcc_back.sv
src/bitmap_pixel_color_converter_core.sv
bench/bitmap_pixel_color_converter_core_tb.sv
